>>> hdl/encrpm_pkg.sv
// Package: item types, state codes and constants for the encoder position and rpm block
`default_nettype none
package encrpm_pkg;

  localparam int QuoW     = 48;
  localparam int DivSteps = QuoW;
  localparam int StepW    = $clog2(DivSteps);

  localparam logic [15:0] MsPerMin = 16'd60000;
  localparam logic [15:0] CprReset = 16'd15000;

  localparam logic [QuoW-1:0] PosLimit = QuoW'(32'h7FFF_FFFF);
  localparam logic [QuoW-1:0] NegLimit = QuoW'(32'h8000_0000);

  typedef enum logic [0:0] {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MULN,
    ST_MULD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_e_t      command;
    logic [15:0] counter_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_rpm;
    logic signed [31:0] position_count;
    logic        [31:0] elapsed_ms;
    logic               no_time_elapsed;
    logic               speed_saturated;
  } out_item_t;

endpackage
`default_nettype wire

>>> hdl/encoder_position_and_rpm_top.sv
// Top level: encoder position tracking and rpm measurement with an iterative divider
//
// Input channel in_valid/in_ready/in_item carries two kinds of item. A tick
// advances the millisecond clock and gives no result. A sample
// updates the position from the 16-bit counter and yields one result on
// out_valid/out_ready/out_item: speed, position, elapsed time and two flags.
// A sample runs through one shared 32x16 multiplier (numerator, then
// denominator) and a restoring divider that retires one quotient bit a cycle
// over 48 divide steps; when no time has elapsed it skips straight to the
// result. in_ready is low meanwhile.
// A result waits in the output register while the next items are taken; a
// following sample holds in its last step until that result is taken.
// counts_per_rev is written through cfg_we/cfg_data; zero acts as one.
// Reset (rst, synchronous) sets counts_per_rev to 15000 and clears position,
// clock and sample history.
`default_nettype none
module encoder_position_and_rpm_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire encrpm_pkg::in_item_t  in_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      encrpm_pkg::out_item_t out_item,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_data
);
  import encrpm_pkg::*;

  state_t state, state_next;

  logic [15:0]      counts_per_rev;
  logic [15:0]      last_counter;
  logic [31:0]      position_acc;
  logic [31:0]      ms_clock;
  logic [31:0]      prev_sample_time;
  logic [31:0]      prev_sample_position;
  logic [31:0]      dt;
  logic [31:0]      mag;
  logic             neg;
  logic             zero_dt;
  logic [QuoW-1:0]  den;
  logic [QuoW-1:0]  dvd;
  logic [QuoW-1:0]  rem;
  logic [StepW-1:0] step;

  logic             in_acc;
  logic             load_out;
  logic [15:0]      diff16;
  logic [31:0]      delta;
  logic [15:0]      cpr_eff;
  logic [31:0]      mul_a;
  logic [15:0]      mul_b;
  logic [QuoW-1:0]  mul_p;
  logic [QuoW:0]    rem_sh;
  logic [QuoW+1:0]  trial;
  logic             take;
  logic [31:0]      speed_fin;
  logic             sat_fin;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  assign diff16  = in_item.counter_value - last_counter;
  assign delta   = position_acc - prev_sample_position;
  assign cpr_eff = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;

  assign mul_a = (state == ST_MULN) ? mag : dt;
  assign mul_b = (state == ST_MULN) ? MsPerMin : cpr_eff;
  assign mul_p = {16'b0, mul_a} * {32'b0, mul_b};

  assign rem_sh = {rem, dvd[QuoW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den};
  assign take   = !trial[QuoW+1];

  always_comb begin
    if (zero_dt) begin
      speed_fin = 32'd0;
      sat_fin   = 1'b0;
    end else if (neg) begin
      sat_fin   = (dvd > NegLimit);
      speed_fin = sat_fin ? 32'h8000_0000 : (32'd0 - dvd[31:0]);
    end else begin
      sat_fin   = (dvd > PosLimit);
      speed_fin = sat_fin ? 32'h7FFF_FFFF : dvd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_item.command == CMD_SAMPLE)) begin
          state_next = ST_DELTA;
        end
      end
      ST_DELTA: begin
        state_next = zero_dt ? ST_DONE : ST_MULN;
      end
      ST_MULN: begin
        state_next = ST_MULD;
      end
      ST_MULD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == StepW'(DivSteps - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev       <= CprReset;
      last_counter         <= 16'd0;
      position_acc         <= 32'd0;
      ms_clock             <= 32'd0;
      prev_sample_time     <= 32'd0;
      prev_sample_position <= 32'd0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        counts_per_rev <= cfg_data;
      end
      if (in_acc) begin
        if (in_item.command == CMD_TICK) begin
          ms_clock <= ms_clock + 32'd1;
        end else begin
          last_counter     <= in_item.counter_value;
          position_acc     <= position_acc + {{16{diff16[15]}}, diff16};
          prev_sample_time <= ms_clock;
        end
      end
      if (state == ST_DELTA) begin
        prev_sample_position <= position_acc;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt      <= ms_clock - prev_sample_time;
      zero_dt <= (ms_clock == prev_sample_time);
    end
    case (state)
      ST_DELTA: begin
        neg <= delta[31];
        mag <= delta[31] ? (32'd0 - delta) : delta;
      end
      ST_MULN: begin
        dvd  <= mul_p;
        rem  <= '0;
        step <= '0;
      end
      ST_MULD: begin
        den <= mul_p;
      end
      ST_DIV: begin
        rem  <= take ? trial[QuoW-1:0] : rem_sh[QuoW-1:0];
        dvd  <= {dvd[QuoW-2:0], take};
        step <= step + StepW'(1);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_item.speed_rpm       <= speed_fin;
      out_item.position_count  <= position_acc;
      out_item.elapsed_ms      <= dt;
      out_item.no_time_elapsed <= zero_dt;
      out_item.speed_saturated <= sat_fin;
    end
  end

  a_tick_adv : assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_item.command == CMD_TICK) |=> ms_clock == $past(ms_clock) + 32'd1)
    else $error("tick did not advance the millisecond clock");

  a_sample_busy : assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_item.command == CMD_SAMPLE) |=> !in_ready)
    else $error("sample did not hold off the input");

  a_zero_dt : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.no_time_elapsed |->
      (out_item.speed_rpm == 32'sd0) && !out_item.speed_saturated)
    else $error("zero elapsed time gave nonzero speed");

  a_sat_val : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.speed_saturated |->
      (out_item.speed_rpm == 32'sh7FFF_FFFF) || (out_item.speed_rpm == 32'sh8000_0000))
    else $error("saturated speed not at a limit");

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench: directed and random checks of the encoder position and rpm block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import encrpm_pkg::*;

  localparam int unsigned MinuteMs     = 60000;
  localparam int          StallLimit   = 2000;
  localparam int          SettleCycles = 60;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int stall_cycles  = 0;

  logic [15:0] cpr_reg   = CprReset;
  logic [15:0] last_cnt  = '0;
  logic [31:0] pos_acc   = '0;
  logic [31:0] ms_now    = '0;
  logic [31:0] prev_time = '0;
  logic [31:0] prev_pos  = '0;
  out_item_t   pending_results[$];
  out_item_t   want_res;

  encoder_position_and_rpm_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_item(in_item_t it);
    logic [15:0] diff16;
    logic [31:0] dt;
    logic [31:0] delta;
    logic [31:0] mag;
    logic [63:0] den;
    logic [63:0] quo;
    out_item_t   res;
    if (it.command == CMD_TICK) begin
      ms_now = ms_now + 32'd1;
      return;
    end
    diff16   = it.counter_value - last_cnt;
    last_cnt = it.counter_value;
    pos_acc  = pos_acc + {{16{diff16[15]}}, diff16};
    dt       = ms_now - prev_time;
    delta    = pos_acc - prev_pos;
    res                = '0;
    res.position_count = pos_acc;
    res.elapsed_ms     = dt;
    if (dt == 32'd0) begin
      res.no_time_elapsed = 1'b1;
    end else begin
      den = 64'((cpr_reg == 16'd0) ? 16'd1 : cpr_reg) * 64'(dt);
      mag = delta[31] ? -delta : delta;
      quo = (64'(mag) * 64'(MinuteMs)) / den;
      if (delta[31]) begin
        if (quo > 64'h8000_0000) begin
          quo = 64'h8000_0000;
          res.speed_saturated = 1'b1;
        end
        res.speed_rpm = -quo[31:0];
      end else begin
        if (quo > 64'h7FFF_FFFF) begin
          quo = 64'h7FFF_FFFF;
          res.speed_saturated = 1'b1;
        end
        res.speed_rpm = quo[31:0];
      end
    end
    prev_time = ms_now;
    prev_pos  = pos_acc;
    pending_results.push_back(res);
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic send_sample(logic [15:0] value);
    in_item_t it;
    it.command       = CMD_SAMPLE;
    it.counter_value = value;
    send_item(it);
  endtask

  task automatic send_ticks(int n);
    in_item_t it;
    it.command = CMD_TICK;
    repeat (n) begin
      it.counter_value = 16'($urandom);
      send_item(it);
    end
  endtask

  // drop valid and wait until the block has nothing left in flight
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_cpr(logic [15:0] value);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cpr_reg = value;
  endtask

  function automatic logic [15:0] pick_cpr();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return CprReset;
      4: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("result with no pending sample");
      end else begin
        want_res = pending_results.pop_front();
        if (out_item.speed_rpm !== want_res.speed_rpm)
          report($sformatf("speed_rpm %0d, expected %0d",
                           out_item.speed_rpm, want_res.speed_rpm));
        if (out_item.position_count !== want_res.position_count)
          report($sformatf("position_count %0d, expected %0d",
                           out_item.position_count, want_res.position_count));
        if (out_item.elapsed_ms !== want_res.elapsed_ms)
          report($sformatf("elapsed_ms %0d, expected %0d",
                           out_item.elapsed_ms, want_res.elapsed_ms));
        if (out_item.no_time_elapsed !== want_res.no_time_elapsed)
          report($sformatf("no_time_elapsed %b, expected %b",
                           out_item.no_time_elapsed, want_res.no_time_elapsed));
        if (out_item.speed_saturated !== want_res.speed_saturated)
          report($sformatf("speed_saturated %b, expected %b",
                           out_item.speed_saturated, want_res.speed_saturated));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_sample(16'h0000);
    send_ticks(1);
    send_sample(16'h7FFF);
    send_ticks(1);
    send_sample(16'hFFFF);
    send_ticks(3);
    send_sample(16'hFFFF);
    send_ticks(2);
    send_sample(16'h0002);
    send_sample(16'hFFFE);
    send_ticks(7);
    send_sample(16'h5555);
    send_ticks(1);
    send_sample(16'hAAAA);
  endtask

  // largest steps both ways at the smallest, largest and default resolution
  task automatic test_cpr_extremes();
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: write_cpr(16'd0);
        1: write_cpr(16'd1);
        2: write_cpr(16'hFFFF);
        default: write_cpr(CprReset);
      endcase
      send_ticks(1);
      send_sample(last_cnt + 16'h7FFF);
      send_ticks(1);
      send_sample(last_cnt + 16'h8000);
    end
  endtask

  task automatic test_random(int send_pct, int recv_pct, int n_items);
    int          sent;
    int          n;
    logic [15:0] value;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    write_cpr(pick_cpr());
    while (sent < n_items) begin
      if ($urandom_range(99) < 3) write_cpr(pick_cpr());
      case ($urandom_range(39))
        0: n = $urandom_range(41, 120);
        1, 2, 3, 4, 5, 6, 7, 8: n = $urandom_range(4, 20);
        default: n = $urandom_range(0, 3);
      endcase
      send_ticks(n);
      case ($urandom_range(9))
        0, 1, 2: value = 16'($urandom);
        3: value = last_cnt + 16'h7FFF;
        4: value = last_cnt + 16'h8000;
        5: value = last_cnt;
        default: value = last_cnt + 16'($urandom_range(0, 1000)) - 16'd500;
      endcase
      send_sample(value);
      sent += n + 1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 11;
    recv_idle_pct = 79;
    test_directed();
    test_cpr_extremes();
    test_random(11, 79, 470);
    test_random(79, 11, 470);
    test_random(0, 0, 470);
    quiesce();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> encoder_position_and_rpm_top.f
hdl/encrpm_pkg.sv
hdl/encoder_position_and_rpm_top.sv
dv/testbench.sv
